### design/ssil_pkg.sv
// package: widths, codes, record type and ring address helper for the sorted list
`timescale 1ns / 1ps
`default_nettype none
package ssil_pkg;

  // list geometry
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;

  // beat field widths
  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DEL_HEAD = 3'd1,
    OP_DEL_TAIL = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_TRAVERSE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_RESP,
    S_TRV,
    S_TRV_END
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
  } entry_t;

  // physical slot of a logical position in the ring
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/ssil_in_if.sv
// interface: request channel of the sorted list
`timescale 1ns / 1ps
`default_nettype none
interface ssil_in_if;
  import ssil_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  item_id;
  logic [AGE_W-1:0] item_age;

  modport source (output valid, output operation, output item_id, output item_age,
                  input ready);
  modport sink   (input valid, input operation, input item_id, input item_age,
                  output ready);
endinterface
`default_nettype wire

### design/ssil_out_if.sv
// interface: result channel of the sorted list
`timescale 1ns / 1ps
`default_nettype none
interface ssil_out_if;
  import ssil_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     entry_id;
  logic [AGE_W-1:0]    entry_age;
  logic [COUNT_W-1:0]  entry_count;
  logic                last_result;

  modport source (output valid, output status, output entry_id, output entry_age,
                  output entry_count, output last_result, input ready);
  modport sink   (input valid, input status, input entry_id, input entry_age,
                  input entry_count, input last_result, output ready);
endinterface
`default_nettype wire

### design/stable_sorted_insert_list.sv
// Stable sorted list of id/age records kept in age order, head at smallest age.
//
// Requests arrive on in_i (valid/ready), results leave on out_o (valid/ready).
// Records live in a ring held in a single synchronous memory (one write port,
// one read port, registered read data) with a head pointer and a count.
// Remove head, remove tail, clear, unused codes, an insert into an empty or
// full list and any request on an empty list finish at the accepting edge;
// the result beat is valid in the next cycle.
// A sorted insert walks from the tail toward the head, reading one entry and
// writing it one slot up per cycle until an age not above the new one or the
// head is passed, writes the new record, then responds once the output is free.
// A traverse emits one beat per stored entry, reading each entry only when the
// single output register is free and loading it once the read data returns.
// A request is taken only while the block is idle and the output register is
// free or being drained; a stalled receiver simply holds the current beat.
// Reset clears the count and head pointer; the record memory is not cleared
// and is only read at occupied positions.
`timescale 1ns / 1ps
`default_nettype none
module stable_sorted_insert_list (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssil_in_if.sink   in_i,
  ssil_out_if.source out_o
);
  import ssil_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    occ_q, occ_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic                rd_pend_q;
  logic [ID_W-1:0]     id_q, id_d;
  logic [AGE_W-1:0]    age_q, age_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ID_W-1:0]     out_id_q;
  logic [AGE_W-1:0]    out_age_q;
  logic [COUNT_W-1:0]  out_cnt_q;
  logic                out_last_q;

  entry_t              store_q [CAPACITY];
  entry_t              rd_data_q;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;

  logic                out_free;
  logic                out_load;
  status_e             ld_status;
  logic [ID_W-1:0]     ld_id;
  logic [AGE_W-1:0]    ld_age;
  logic                ld_last;
  logic [IDX_W-1:0]    tail_idx;
  logic                trv_last;

  assign out_free = !out_valid_q || out_o.ready;
  assign tail_idx = IDX_W'(occ_q - CNT_W'(1));
  assign trv_last = ((CNT_W'(k_q) + CNT_W'(1)) == occ_q);

  // next state, memory access and result load
  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    head_d    = head_q;
    k_d       = k_q;
    id_d      = id_q;
    age_d     = age_q;
    in_i.ready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;
    ld_status = ST_OK;
    ld_id     = '0;
    ld_age    = '0;
    ld_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_i.ready = out_free;
        if (in_i.valid && out_free) begin
          case (op_e'(in_i.operation))
            OP_INSERT: begin
              if (occ_q >= CNT_W'(CAPACITY)) begin
                out_load  = 1'b1;
                ld_status = ST_FULL;
              end else if (occ_q == '0) begin
                wr_en    = 1'b1;
                wr_addr  = head_q;
                wr_data  = '{id: in_i.item_id, age: in_i.item_age};
                occ_d    = occ_q + CNT_W'(1);
                out_load = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ring_addr(head_q, tail_idx);
                k_d     = tail_idx;
                id_d    = in_i.item_id;
                age_d   = in_i.item_age;
                state_d = S_INS;
              end
            end
            OP_DEL_HEAD: begin
              out_load = 1'b1;
              if (occ_q == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                head_d = ring_addr(head_q, IDX_W'(1));
                occ_d  = occ_q - CNT_W'(1);
              end
            end
            OP_DEL_TAIL: begin
              out_load = 1'b1;
              if (occ_q == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                occ_d = occ_q - CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              occ_d    = '0;
            end
            OP_TRAVERSE: begin
              if (occ_q == '0) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                k_d     = '0;
                state_d = S_TRV;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // read data of logical k is here: shift it up or drop the new record in
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ring_addr(head_q, k_q + IDX_W'(1));
        if (rd_data_q.age > age_q) begin
          wr_data = rd_data_q;
          if (k_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_addr(head_q, k_q - IDX_W'(1));
            k_d     = k_q - IDX_W'(1);
          end
        end else begin
          wr_data = '{id: id_q, age: age_q};
          occ_d   = occ_q + CNT_W'(1);
          state_d = S_RESP;
        end
      end

      // new record becomes the head
      S_INS_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = '{id: id_q, age: age_q};
        occ_d   = occ_q + CNT_W'(1);
        state_d = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // one read in flight at most, issued only when the output slot is free
      S_TRV: begin
        if (rd_pend_q) begin
          out_load = 1'b1;
          ld_id    = rd_data_q.id;
          ld_age   = rd_data_q.age;
          ld_last  = 1'b0;
        end else if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = ring_addr(head_q, k_q);
          if (trv_last) begin
            state_d = S_TRV_END;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end

      S_TRV_END: begin
        out_load = 1'b1;
        ld_id    = rd_data_q.id;
        ld_age   = rd_data_q.age;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      head_q      <= '0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      head_q    <= head_d;
      k_q       <= k_d;
      rd_pend_q <= rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // latched request and output beat payload
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    age_q <= age_d;
    if (out_load) begin
      out_status_q <= ld_status;
      out_id_q     <= ld_id;
      out_age_q    <= ld_age;
      out_cnt_q    <= COUNT_W'(occ_d);
      out_last_q   <= ld_last;
    end
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_id    = out_id_q;
  assign out_o.entry_age   = out_age_q;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.last_result = out_last_q;

endmodule
`default_nettype wire
